// ----- rtl/packet_header_statistics_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the packet header statistics block.
// ----------------------------------------------------------------------------
`ifndef PACKET_HEADER_STATISTICS_MACROS_SVH
`define PACKET_HEADER_STATISTICS_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define PHS_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define PHS_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/phs_pkg.sv -----
// ----------------------------------------------------------------------------
// phs_pkg
// Types and constants shared by the packet header statistics modules.
// ----------------------------------------------------------------------------
package phs_pkg;

   // Item kinds on the request channel.
   localparam logic KindByte = 1'b0;
   localparam logic KindRead = 1'b1;

   // Parser positions and header constants.
   localparam logic [15:0] IdlePos       = 16'hFFFF;
   localparam logic [15:0] PosEthHi      = 16'd12;
   localparam logic [15:0] PosEthLo      = 16'd13;
   localparam logic [15:0] PosVersion    = 16'd14;
   localparam logic [15:0] PosProto      = 16'd23;
   localparam logic [15:0] PosIcmpType   = 16'd34;
   localparam logic [15:0] PosIcmpCode   = 16'd35;
   localparam logic [15:0] PosTcpOffset  = 16'd46;
   localparam logic [15:0] PosTcpFlags   = 16'd47;
   localparam logic [15:0] PosOptStart   = 16'd54;
   localparam logic [7:0]  OptStart      = 8'd54;
   localparam logic [7:0]  OptEndBase    = 8'd34;
   localparam logic [5:0]  TcpBaseHdrLen = 6'd20;
   localparam logic [15:0] EthIpv4       = 16'h0800;
   localparam logic [15:0] EthArp        = 16'h0806;
   localparam logic [15:0] EthShortLimit = 16'h0600;
   localparam logic [3:0]  VersionIpv6   = 4'h6;
   localparam logic [7:0]  ProtoIcmp     = 8'd1;
   localparam logic [7:0]  ProtoTcp      = 8'd6;
   localparam logic [7:0]  OptKindEnd    = 8'd0;
   localparam logic [7:0]  OptKindNop    = 8'd1;
   localparam logic [7:0]  OptMinLen     = 8'd2;

   // Option walk and IPv4 flag bits.
   localparam int FlagWalk = 0;
   localparam int FlagNop  = 1;
   localparam int FlagLen  = 2;
   localparam int FlagIpv4 = 3;

   // Class and flag counter slots.
   localparam int NumCf     = 10;
   localparam int CfIpv6    = 0;
   localparam int CfIpv4    = 1;
   localparam int CfArp     = 2;
   localparam int CfShort   = 3;
   localparam int CfTcpFlag = 4;
   localparam int NumTcpFlags = 6;

   // Histogram regions.
   localparam logic [1:0] HistProto = 2'd0;
   localparam logic [1:0] HistType  = 2'd1;
   localparam logic [1:0] HistCode  = 2'd2;
   localparam logic [1:0] HistOpt   = 2'd3;
   localparam int HistDepth = 1024;
   localparam int HistAw    = 10;

   // Statistic read indexes.
   localparam logic [10:0] StatTotal   = 11'd0;
   localparam logic [10:0] StatSum     = 11'd1;
   localparam logic [10:0] StatMin     = 11'd2;
   localparam logic [10:0] StatMax     = 11'd3;
   localparam logic [10:0] StatCfBase  = 11'd4;
   localparam logic [10:0] StatHistBase = 11'd14;
   localparam logic [10:0] StatLast    = 11'd1037;

   localparam int ValueWidth = 48;

   // One access to the histogram memory.
   typedef struct packed {
      logic              valid;
      logic              bump;
      logic [HistAw-1:0] addr;
   } hist_req_type;

endpackage

// ----- rtl/phs_parser.sv -----
// ----------------------------------------------------------------------------
// phs_parser
// Byte parser with the packet-level and class/flag counters, and the
// statistic read decode. Issues at most one histogram access per item.
// ----------------------------------------------------------------------------
module phs_parser import phs_pkg::*; #(
   parameter int CounterWidth = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  logic                  req_kind,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_first_byte,
   input  logic                  req_last_byte,
   input  logic [15:0]           req_wire_length,
   input  logic [10:0]           req_stat_index,
   output hist_req_type          hist_req,
   output logic                  rd_hist_sel,
   output logic                  rd_ok,
   output logic [ValueWidth-1:0] rd_value
);

   localparam logic [CounterWidth-1:0] CntMax = {CounterWidth{1'b1}};

   logic [15:0]             pos_ff, pos_in;
   logic [31:0]             latch_ff, latch_in;
   logic [7:0]              cur_ff, cur_in;
   logic [3:0]              flags_ff, flags_in;
   logic [CounterWidth-1:0] total_ff, total_in;
   logic [ValueWidth-1:0]   sum_ff, sum_in;
   logic [15:0]             min_ff, min_in;
   logic [15:0]             max_ff, max_in;
   logic [CounterWidth-1:0] cf_ff [NumCf];
   logic [NumCf-1:0]        cf_bump;

   // Parse one byte and work out the next parser state.
   always_comb begin : parse_comb
      logic [15:0] p;
      logic [31:0] lat;
      logic [7:0]  cur;
      logic [3:0]  fl;
      logic [7:0]  proto;
      logic [7:0]  ender;
      logic [7:0]  b;
      logic [5:0]  hl;
      logic [8:0]  nx;
      logic        ipv4;
      logic [ValueWidth:0] sum_wide;

      pos_in   = pos_ff;
      latch_in = latch_ff;
      cur_in   = cur_ff;
      flags_in = flags_ff;
      total_in = total_ff;
      sum_in   = sum_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      cf_bump  = '0;
      hist_req = '0;
      p     = pos_ff;
      lat   = latch_ff;
      cur   = cur_ff;
      fl    = flags_ff;
      b     = req_data_byte;
      hl    = '0;
      nx    = '0;
      sum_wide = '0;
      proto = lat[23:16];
      ender = lat[31:24];
      ipv4  = fl[FlagIpv4];

      if (fire && req_kind == KindByte) begin
         // Packet start: length statistics and a fresh parser state.
         if (req_first_byte) begin
            if (total_ff == '0 || req_wire_length < min_ff) begin
               min_in = req_wire_length;
            end
            if (req_wire_length > max_ff) begin
               max_in = req_wire_length;
            end
            if (total_ff != CntMax) begin
               total_in = total_ff + 1'b1;
            end
            sum_wide = {1'b0, sum_ff} + (ValueWidth + 1)'(req_wire_length);
            sum_in = sum_wide[ValueWidth] ? {ValueWidth{1'b1}} : sum_wide[ValueWidth-1:0];
            p   = '0;
            lat = '0;
            cur = '0;
            fl  = '0;
         end
         proto = lat[23:16];
         ender = lat[31:24];
         ipv4  = fl[FlagIpv4];

         if (p != IdlePos) begin
            if (p == PosEthHi) begin
               lat[15:8] = b;
            end else if (p == PosEthLo) begin
               lat[7:0] = b;
            end else if (p == PosVersion) begin
               // Classing happens on the version byte.
               if (b[7:4] == VersionIpv6) begin
                  cf_bump[CfIpv6] = 1'b1;
               end else if (lat[15:0] == EthIpv4) begin
                  cf_bump[CfIpv4] = 1'b1;
                  fl[FlagIpv4]    = 1'b1;
               end else if (lat[15:0] == EthArp) begin
                  cf_bump[CfArp] = 1'b1;
               end else if (lat[15:0] < EthShortLimit) begin
                  cf_bump[CfShort] = 1'b1;
               end
            end else if (p == PosProto && ipv4) begin
               lat[23:16] = b;
               hist_req = '{valid: 1'b1, bump: 1'b1, addr: {HistProto, b}};
            end else if (ipv4 && proto == ProtoIcmp && p == PosIcmpType) begin
               hist_req = '{valid: 1'b1, bump: 1'b1, addr: {HistType, b}};
            end else if (ipv4 && proto == ProtoIcmp && p == PosIcmpCode) begin
               hist_req = '{valid: 1'b1, bump: 1'b1, addr: {HistCode, b}};
            end else if (ipv4 && proto == ProtoTcp && p == PosTcpOffset) begin
               // Options exist when the TCP header is longer than its base.
               hl = {b[7:4], 2'b00};
               if (hl > TcpBaseHdrLen) begin
                  lat[31:24]   = OptEndBase + {2'b00, hl};
                  cur          = OptStart;
                  fl[FlagWalk] = 1'b1;
               end
            end else if (ipv4 && proto == ProtoTcp && p == PosTcpFlags) begin
               for (int i = 0; i < NumTcpFlags; i++) begin
                  cf_bump[CfTcpFlag + i] = b[i];
               end
            end else if (fl[FlagWalk] && p >= PosOptStart) begin
               // Option walk: a kind byte, then a length byte for long options.
               if (fl[FlagLen]) begin
                  fl[FlagLen] = 1'b0;
                  if (b < OptMinLen) begin
                     fl[FlagWalk] = 1'b0;
                  end else begin
                     nx = {1'b0, cur} + {1'b0, b};
                     if (nx >= {1'b0, ender}) begin
                        fl[FlagWalk] = 1'b0;
                     end else begin
                        cur = nx[7:0];
                     end
                  end
               end else if (p == {8'd0, cur}) begin
                  if (b == OptKindEnd) begin
                     hist_req     = '{valid: 1'b1, bump: 1'b1, addr: {HistOpt, OptKindEnd}};
                     fl[FlagWalk] = 1'b0;
                  end else if (b == OptKindNop) begin
                     if (!fl[FlagNop]) begin
                        hist_req    = '{valid: 1'b1, bump: 1'b1, addr: {HistOpt, OptKindNop}};
                        fl[FlagNop] = 1'b1;
                     end
                     cur = cur + 1'b1;
                     if (cur >= ender) begin
                        fl[FlagWalk] = 1'b0;
                     end
                  end else begin
                     hist_req = '{valid: 1'b1, bump: 1'b1, addr: {HistOpt, b}};
                     if ({1'b0, cur} + 9'd1 >= {1'b0, ender}) begin
                        fl[FlagWalk] = 1'b0;
                     end else begin
                        fl[FlagLen] = 1'b1;
                     end
                  end
               end
            end
            pos_in = p + 1'b1;
         end else begin
            pos_in = p;
         end

         if (req_last_byte) begin
            pos_in       = IdlePos;
            fl[FlagWalk] = 1'b0;
            fl[FlagLen]  = 1'b0;
         end
         latch_in = lat;
         cur_in   = cur;
         flags_in = fl;
      end else if (fire && req_kind == KindRead) begin
         // A histogram read uses the same memory port as an update.
         if (req_stat_index >= StatHistBase && req_stat_index <= StatLast) begin
            hist_req.valid = 1'b1;
            hist_req.addr  = HistAw'(req_stat_index - StatHistBase);
         end
      end
   end

   // Statistic read decode for the values held in flip-flops.
   always_comb begin : read_comb
      logic [10:0] cf_off;

      cf_off      = req_stat_index - StatCfBase;
      rd_value    = '0;
      rd_ok       = (req_stat_index <= StatLast);
      rd_hist_sel = (req_stat_index >= StatHistBase) && rd_ok;
      if (req_stat_index == StatTotal) begin
         rd_value = ValueWidth'(total_ff);
      end else if (req_stat_index == StatSum) begin
         rd_value = sum_ff;
      end else if (req_stat_index == StatMin) begin
         rd_value = ValueWidth'(min_ff);
      end else if (req_stat_index == StatMax) begin
         rd_value = ValueWidth'(max_ff);
      end else if (req_stat_index < StatHistBase) begin
         rd_value = ValueWidth'(cf_ff[cf_off[3:0]]);
      end
   end

   // Parser and counter registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         latch_ff <= '0;
         cur_ff   <= '0;
         flags_ff <= '0;
         total_ff <= '0;
         sum_ff   <= '0;
         min_ff   <= '0;
         max_ff   <= '0;
         for (int k = 0; k < NumCf; k++) begin
            cf_ff[k] <= '0;
         end
      end else begin
         pos_ff   <= pos_in;
         latch_ff <= latch_in;
         cur_ff   <= cur_in;
         flags_ff <= flags_in;
         total_ff <= total_in;
         sum_ff   <= sum_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
         for (int k = 0; k < NumCf; k++) begin
            if (cf_bump[k] && cf_ff[k] != CntMax) begin
               cf_ff[k] <= cf_ff[k] + 1'b1;
            end
         end
      end
   end

endmodule

// ----- rtl/phs_hist_mem.sv -----
// ----------------------------------------------------------------------------
// phs_hist_mem
// Histogram memory with read-modify-write increments, forwarding of the
// last write, and a clearing pass after reset.
// ----------------------------------------------------------------------------
module phs_hist_mem import phs_pkg::*; #(
   parameter int CounterWidth = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  hist_req_type            hist_req,
   output logic                    mem_ready,
   output logic [CounterWidth-1:0] rd_data
);

   localparam logic [CounterWidth-1:0] CntMax = {CounterWidth{1'b1}};

   logic [CounterWidth-1:0] mem [HistDepth];
   logic [CounterWidth-1:0] rdata_ff;
   logic [HistAw:0]         clr_ff;
   logic                    s1_v_ff;
   logic                    s1_bump_ff;
   logic [HistAw-1:0]       s1_addr_ff;
   logic                    wv_ff;
   logic [HistAw-1:0]       wa_ff;
   logic [CounterWidth-1:0] wd_ff;
   logic [CounterWidth-1:0] cur;
   logic [CounterWidth-1:0] incr;
   logic                    clearing;
   logic                    do_write;

   assign clearing  = !clr_ff[HistAw];
   assign mem_ready = !clearing;

   // The most recent write is not yet visible in the read data.
   assign cur      = (wv_ff && wa_ff == s1_addr_ff) ? wd_ff : rdata_ff;
   assign incr     = (cur == CntMax) ? cur : cur + 1'b1;
   assign rd_data  = cur;
   assign do_write = s1_v_ff && s1_bump_ff;

   // Memory array: registered read, one write port shared with clearing.
   always_ff @(posedge clock) begin
      rdata_ff <= mem[hist_req.addr];
      if (clearing) begin
         mem[clr_ff[HistAw-1:0]] <= '0;
      end else if (do_write) begin
         mem[s1_addr_ff] <= incr;
      end
   end

   // Control: clear counter, access stage and forwarding valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         s1_v_ff <= 1'b0;
         wv_ff   <= 1'b0;
      end else begin
         if (clearing) begin
            clr_ff <= clr_ff + 1'b1;
         end
         s1_v_ff <= hist_req.valid;
         wv_ff   <= do_write && !clearing;
      end
   end

   // Payload of the access stage and of the last write.
   always_ff @(posedge clock) begin
      s1_bump_ff <= hist_req.bump;
      s1_addr_ff <= hist_req.addr;
      wa_ff      <= s1_addr_ff;
      wd_ff      <= incr;
   end

endmodule

// ----- rtl/packet_header_statistics.sv -----
// ----------------------------------------------------------------------------
// packet_header_statistics
// Ethernet/IPv4/TCP header statistics: parses packet bytes, keeps saturating
// counters and histograms, and answers statistic reads.
//
//   Channel   Direction  Handshake            Carries
//   req_      in         req_valid/req_ready  packet byte or statistic read
//   rsp_      out        rsp_valid/rsp_ready  one statistic per read item
//
// One item is taken per cycle while req_ready is high; a byte never waits
// on a histogram update. A read passes the read stage, then the result queue.
// After reset a clearing pass writes all 1024 histogram entries, one a cycle;
// req_ready stays low until the pass is done.
// A three-entry result queue lets reads keep streaming while rsp_ready is low
// for short spells; req_ready drops once the queue and the read in flight fill it.
// ----------------------------------------------------------------------------
module packet_header_statistics import phs_pkg::*; #(
   parameter int COUNTER_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_kind,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_first_byte,
   input  logic                  req_last_byte,
   input  logic [15:0]           req_wire_length,
   input  logic [10:0]           req_stat_index,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [ValueWidth-1:0] rsp_stat_value,
   output logic                  rsp_index_valid
);

   localparam int QDepth = 3;

   hist_req_type             hist_req;
   logic                     fire;
   logic                     mem_ready;
   logic [COUNTER_WIDTH-1:0] hist_data;
   logic                     rd_hist_sel;
   logic                     rd_ok;
   logic [ValueWidth-1:0]    rd_value;

   logic                     s1_rd_ff;
   logic                     s1_hsel_ff;
   logic                     s1_ok_ff;
   logic [ValueWidth-1:0]    s1_val_ff;
   logic [ValueWidth-1:0]    s1_result;

   logic [ValueWidth-1:0]    q_val_ff [QDepth];
   logic                     q_ok_ff  [QDepth];
   logic [1:0]               q_wr_ff, q_rd_ff, q_cnt_ff;
   logic                     push, pop;

   // Accept while the queue has room for everything in flight.
   assign req_ready = mem_ready && ({1'b0, q_cnt_ff} + {2'b00, s1_rd_ff} < 3'(QDepth));
   assign fire      = req_valid && req_ready;

   phs_parser #(.CounterWidth(COUNTER_WIDTH)) u_parser (
      .clock           (clock),
      .reset           (reset),
      .fire            (fire),
      .req_kind        (req_kind),
      .req_data_byte   (req_data_byte),
      .req_first_byte  (req_first_byte),
      .req_last_byte   (req_last_byte),
      .req_wire_length (req_wire_length),
      .req_stat_index  (req_stat_index),
      .hist_req        (hist_req),
      .rd_hist_sel     (rd_hist_sel),
      .rd_ok           (rd_ok),
      .rd_value        (rd_value)
   );

   phs_hist_mem #(.CounterWidth(COUNTER_WIDTH)) u_hist (
      .clock     (clock),
      .reset     (reset),
      .hist_req  (hist_req),
      .mem_ready (mem_ready),
      .rd_data   (hist_data)
   );

   // Read stage, aligned with the histogram memory read.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_rd_ff <= 1'b0;
      end else begin
         s1_rd_ff <= fire && req_kind == KindRead;
      end
   end

   always_ff @(posedge clock) begin
      s1_hsel_ff <= rd_hist_sel;
      s1_ok_ff   <= rd_ok;
      s1_val_ff  <= rd_value;
   end

   assign s1_result = s1_hsel_ff ? ValueWidth'(hist_data) : s1_val_ff;

   // Result queue.
   assign push = s1_rd_ff;
   assign pop  = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ff  <= '0;
         q_rd_ff  <= '0;
         q_cnt_ff <= '0;
      end else begin
         if (push) begin
            q_wr_ff <= (q_wr_ff == 2'(QDepth - 1)) ? '0 : q_wr_ff + 1'b1;
         end
         if (pop) begin
            q_rd_ff <= (q_rd_ff == 2'(QDepth - 1)) ? '0 : q_rd_ff + 1'b1;
         end
         q_cnt_ff <= q_cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_val_ff[q_wr_ff] <= s1_result;
         q_ok_ff[q_wr_ff]  <= s1_ok_ff;
      end
   end

   assign rsp_valid       = (q_cnt_ff != '0);
   assign rsp_stat_value  = q_val_ff[q_rd_ff];
   assign rsp_index_valid = q_ok_ff[q_rd_ff];

endmodule

// ----- rtl/phs_checker.sv -----
// ----------------------------------------------------------------------------
// phs_checker
// Port-level checks of the packet header statistics block.
// ----------------------------------------------------------------------------
`include "packet_header_statistics_macros.svh"

module phs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [47:0] rsp_stat_value,
   input logic        rsp_index_valid
);

   // A stalled item stays put.
   `PHS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_stat_value), "stalled item changed")

   // A read of a nonexistent statistic returns zero.
   `PHS_ASSERT(a_bad_index_zero, clock, reset, rsp_valid && !rsp_index_valid |-> rsp_stat_value == 48'd0, "invalid index gave nonzero value")

   // Reset empties the result queue and starts the clearing pass.
   `PHS_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid && !req_ready, "activity right after reset")

endmodule

bind packet_header_statistics phs_checker u_phs_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_stat_value  (rsp_stat_value),
   .rsp_index_valid (rsp_index_valid)
);
